[rtl/phlt_pkg.sv]
// shared types and constants of the passive host learning table
package phlt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam logic [15:0] ETYPE_ARP = 16'h0806;
  localparam logic [15:0] ETYPE_IP4 = 16'h0800;
  localparam logic [15:0] HTYPE_ETH = 16'h0001;
  localparam logic [15:0] PTYPE_IP4 = 16'h0800;
  localparam logic [5:0]  ARP_MIN_LAST = 6'd41;
  localparam logic [5:0]  IP4_MIN_LAST = 6'd33;
  localparam logic [5:0]  POS_MAX      = 6'd63;

  typedef enum logic [1:0] {
    CFG_HOST_LIMIT  = 2'd0,
    CFG_SUBNET_ADDR = 2'd1,
    CFG_SUBNET_MASK = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_FRAME   = 1'b0,
    CMD_SUGGEST = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LRN_ISSUE,
    ST_LRN_WAIT,
    ST_SUG_DIV,
    ST_SUG_PROBE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [31:0] seed;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        host_added;
    logic        address_found;
    logic [31:0] suggested_address;
    logic [5:0]  hosts_known;
    logic [31:0] frames_accepted;
  } out_item_t;

  // token travelling down the row of cells
  typedef struct packed {
    logic        valid;
    logic        probe;
    logic [31:0] key;
    logic [47:0] mac;
    logic        hit;
  } tok_t;

  // append request broadcast to all cells
  typedef struct packed {
    logic        we;
    logic [31:0] addr;
    logic [47:0] mac;
  } app_t;

endpackage

[rtl/phlt_cell.sv]
// one table entry: holds an address and mac, compares the passing token
module phlt_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [phlt_pkg::IDX_W-1:0] cell_idx_i,
  input  logic [phlt_pkg::CNT_W-1:0] entry_count_i,
  input  phlt_pkg::app_t           app_i,
  input  phlt_pkg::tok_t           tok_i,
  output phlt_pkg::tok_t           tok_o
);
  import phlt_pkg::*;

  logic [31:0] addr_q;
  logic [47:0] mac_q;
  tok_t        tok_q, tok_d;
  logic        active;
  logic        match;

  assign active = CNT_W'(cell_idx_i) < entry_count_i;
  assign match  = tok_i.valid && active && (addr_q == tok_i.key);
  assign tok_o  = tok_q;

  // token seen by the next cell: hit once any active entry matched
  always_comb begin
    tok_d     = tok_i;
    tok_d.hit = tok_i.hit | match;
  end

  // entry storage: write on append, refresh on first match
  always_ff @(posedge clk_i) begin
    if (app_i.we && (CNT_W'(cell_idx_i) == entry_count_i)) begin
      addr_q <= app_i.addr;
      mac_q  <= app_i.mac;
    end else if (tok_i.valid && !tok_i.probe && match && !tok_i.hit) begin
      mac_q <= tok_i.mac;
    end
  end

  // hand the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

endmodule

[rtl/phlt_mod_unit.sv]
// restoring remainder unit, one quotient bit per cycle
module phlt_mod_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  import phlt_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] dvd_q;
  logic [31:0] dvs_q;
  logic [31:0] rem_q;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial  = {rem_q, dvd_q[31]};
  assign diff   = trial - {1'b0, dvs_q};
  assign done_o = done_q;
  assign rem_o  = rem_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= trial >= {1'b0, dvs_q} ? diff[31:0] : trial[31:0];
    end
  end

endmodule

[rtl/passive_host_learning_table_core.sv]
// top level: frame parser, control sequencer, remainder unit and row of table cells
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o   | in_data_i (in_item_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// a final byte of a frame that names a sender sends a lookup token down the row,
// one cell per cycle. a suggest on a degenerate subnet goes straight to emit;
// else the remainder unit picks the start offset, then tries probes walk down
// the row (tries is at most entries+1). reset clears count, totals and parse
// state, not entries.
// the input stalls until the result is registered; a stalled output holds emit.
module passive_host_learning_table_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  phlt_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output phlt_pkg::out_item_t   out_data_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [31:0]           cfg_data_i
);
  import phlt_pkg::*;

  // configuration
  logic [5:0]  host_limit_q;
  logic [31:0] subnet_addr_q;
  logic [31:0] subnet_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_limit_q  <= 6'd32;
      subnet_addr_q <= '0;
      subnet_mask_q <= 32'hFFFF_FF00;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HOST_LIMIT:  host_limit_q  <= cfg_data_i[5:0];
        CFG_SUBNET_ADDR: subnet_addr_q <= cfg_data_i;
        CFG_SUBNET_MASK: subnet_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0] total_q, total_d;
  logic [5:0]  pos_q, pos_d;
  logic [15:0] kind_q, kind_d;
  logic        good_q, good_d;
  logic [47:0] shw_q, shw_d;
  logic [31:0] sip_q, sip_d;
  logic [31:0] lkey_q, lkey_d;
  logic [47:0] lmac_q, lmac_d;
  logic        res_kind_q, res_kind_d;
  logic        res_added_q, res_added_d;
  logic        res_found_q, res_found_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic [31:0] range_q, range_d;
  logic [31:0] first_q, first_d;
  logic [31:0] off_q, off_d;
  logic [CNT_W:0] tries_q, tries_d;
  logic [CNT_W:0] issued_q, issued_d;
  logic [CNT_W:0] returned_q, returned_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  tok_t tok [TABLE_DEPTH+1];
  tok_t tok_head;
  tok_t chain_out;
  app_t app;

  logic        acc;
  logic        frame_ok;
  logic [31:0] network, broadcast, first_c, last_c, range_c;
  logic        degen;
  logic [CNT_W:0] tries_c;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_rem;
  logic        room;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign tok[0]     = tok_head;
  assign chain_out  = tok[TABLE_DEPTH];
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // subnet arithmetic for suggest
  assign network   = subnet_addr_q & subnet_mask_q;
  assign broadcast = network | ~subnet_mask_q;
  assign first_c   = network + 32'd1;
  assign last_c    = broadcast - 32'd1;
  assign degen     = first_c >= last_c;
  assign range_c   = last_c - first_c + 32'd1;
  assign tries_c   = (range_c < 32'(count_q) + 32'd1)
                     ? (CNT_W+1)'(range_c)
                     : (CNT_W+1)'(count_q) + (CNT_W+1)'(1);
  assign room      = (count_q < CNT_W'(TABLE_DEPTH)) &&
                     ((CNT_W > 6) ? (count_q < CNT_W'(host_limit_q))
                                  : (7'(count_q) < 7'(host_limit_q)));

  // byte parser
  always_comb begin
    kind_d = kind_q;
    good_d = good_q;
    shw_d  = shw_q;
    sip_d  = sip_q;
    if (pos_q >= 6'd6 && pos_q <= 6'd11) begin
      shw_d = {shw_q[39:0], in_data_i.frame_byte};
    end else if (pos_q == 6'd12 || pos_q == 6'd13) begin
      kind_d = {kind_q[7:0], in_data_i.frame_byte};
    end else if (pos_q >= 6'd14 && kind_q == ETYPE_ARP) begin
      if (pos_q == 6'd14 && in_data_i.frame_byte != HTYPE_ETH[15:8]) good_d = 1'b0;
      if (pos_q == 6'd15 && in_data_i.frame_byte != HTYPE_ETH[7:0])  good_d = 1'b0;
      if (pos_q == 6'd16 && in_data_i.frame_byte != PTYPE_IP4[15:8]) good_d = 1'b0;
      if (pos_q == 6'd17 && in_data_i.frame_byte != PTYPE_IP4[7:0])  good_d = 1'b0;
      if (pos_q == 6'd18 && in_data_i.frame_byte != 8'd6) good_d = 1'b0;
      if (pos_q == 6'd19 && in_data_i.frame_byte != 8'd4) good_d = 1'b0;
      if (pos_q >= 6'd22 && pos_q <= 6'd27) shw_d = {shw_q[39:0], in_data_i.frame_byte};
      if (pos_q >= 6'd28 && pos_q <= 6'd31) sip_d = {sip_q[23:0], in_data_i.frame_byte};
    end else if (pos_q >= 6'd14 && kind_q == ETYPE_IP4) begin
      if (pos_q == 6'd14 && in_data_i.frame_byte[7:4] != 4'd4) good_d = 1'b0;
      if (pos_q >= 6'd26 && pos_q <= 6'd29) sip_d = {sip_q[23:0], in_data_i.frame_byte};
    end
    frame_ok = (pos_q >= 6'd13) && good_d &&
               ((kind_d == ETYPE_ARP && pos_q >= ARP_MIN_LAST) ||
                (kind_d == ETYPE_IP4 && pos_q >= IP4_MIN_LAST)) &&
               (sip_d != 32'd0);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    pos_d       = pos_q;
    lkey_d      = lkey_q;
    lmac_d      = lmac_q;
    res_kind_d  = res_kind_q;
    res_added_d = res_added_q;
    res_found_d = res_found_q;
    res_addr_d  = res_addr_q;
    range_d     = range_q;
    first_d     = first_q;
    off_d       = off_q;
    tries_d     = tries_q;
    issued_d    = issued_q;
    returned_d  = returned_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    tok_head    = '0;
    app         = '0;
    app.addr    = lkey_q;
    app.mac     = lmac_q;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_data_i.cmd == CMD_SUGGEST) begin
          res_kind_d  = 1'b1;
          res_added_d = 1'b0;
          res_found_d = 1'b0;
          res_addr_d  = '0;
          range_d     = range_c;
          first_d     = first_c;
          tries_d     = tries_c;
          if (degen) begin
            state_d = ST_EMIT;
          end else begin
            div_start = 1'b1;
            state_d   = ST_SUG_DIV;
          end
        end else if (acc) begin
          pos_d = (pos_q < POS_MAX) ? pos_q + 6'd1 : pos_q;
          if (in_data_i.last_byte) begin
            pos_d       = '0;
            res_kind_d  = 1'b0;
            res_added_d = 1'b0;
            res_found_d = 1'b0;
            res_addr_d  = '0;
            lkey_d      = sip_d;
            lmac_d      = shw_d;
            if (frame_ok) begin
              total_d = total_q + 32'd1;
              state_d = ST_LRN_ISSUE;
            end else begin
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_LRN_ISSUE: begin
        tok_head.valid = 1'b1;
        tok_head.key   = lkey_q;
        tok_head.mac   = lmac_q;
        state_d        = ST_LRN_WAIT;
      end
      ST_LRN_WAIT: begin
        if (chain_out.valid) begin
          if (!chain_out.hit && room) begin
            app.we      = 1'b1;
            count_d     = count_q + CNT_W'(1);
            res_added_d = 1'b1;
          end
          state_d = ST_EMIT;
        end
      end
      ST_SUG_DIV: begin
        if (div_done) begin
          off_d      = div_rem;
          issued_d   = '0;
          returned_d = '0;
          state_d    = ST_SUG_PROBE;
        end
      end
      ST_SUG_PROBE: begin
        if (issued_q < tries_q) begin
          tok_head.valid = 1'b1;
          tok_head.probe = 1'b1;
          tok_head.key   = first_q + off_q;
          off_d          = (off_q + 32'd1 == range_q) ? 32'd0 : off_q + 32'd1;
          issued_d       = issued_q + (CNT_W+1)'(1);
        end
        if (chain_out.valid) begin
          returned_d = returned_q + (CNT_W+1)'(1);
          if (!chain_out.hit && !res_found_q) begin
            res_found_d = 1'b1;
            res_addr_d  = chain_out.key;
          end
          if (returned_q + (CNT_W+1)'(1) == tries_q) state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_d) begin
          out_valid_d             = 1'b1;
          out_d.result_kind       = res_kind_q;
          out_d.host_added        = res_added_q;
          out_d.address_found     = res_found_q;
          out_d.suggested_address = res_addr_q;
          out_d.hosts_known       = 6'(count_q);
          out_d.frames_accepted   = total_q;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      kind_q      <= '0;
      good_q      <= 1'b1;
      shw_q       <= '0;
      sip_q       <= '0;
      out_valid_q <= 1'b0;
      issued_q    <= '0;
      returned_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      issued_q    <= issued_d;
      returned_q  <= returned_d;
      if (acc && in_data_i.cmd == CMD_FRAME) begin
        if (in_data_i.last_byte) begin
          kind_q <= '0;
          good_q <= 1'b1;
          shw_q  <= '0;
          sip_q  <= '0;
        end else begin
          kind_q <= kind_d;
          good_q <= good_d;
          shw_q  <= shw_d;
          sip_q  <= sip_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    lkey_q      <= lkey_d;
    lmac_q      <= lmac_d;
    res_kind_q  <= res_kind_d;
    res_added_q <= res_added_d;
    res_found_q <= res_found_d;
    res_addr_q  <= res_addr_d;
    range_q     <= range_d;
    first_q     <= first_d;
    off_q       <= off_d;
    tries_q     <= tries_d;
    out_q       <= out_d;
  end

  phlt_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_data_i.seed),
    .divisor_i  (range_c),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // row of table cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    phlt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cell_idx_i    (IDX_W'(i)),
      .entry_count_i (count_q),
      .app_i         (app),
      .tok_i         (tok[i]),
      .tok_o         (tok[i+1])
    );
  end

endmodule

[dv/tb_passive_host_learning_table_core.sv]
// self-checking testbench of the passive host learning table core
module tb_passive_host_learning_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import phlt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  passive_host_learning_table_core u_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // table mirror and settings
  logic [31:0] host_ip[TABLE_DEPTH];
  logic [47:0] host_mac[TABLE_DEPTH];
  int unsigned n_hosts, n_accepted, pos, kind;
  bit          hdr_ok;
  logic [47:0] cur_mac;
  logic [31:0] cur_ip;
  logic [5:0]  lim_reg = 6'd32;
  logic [31:0] net_reg = 32'h0, mask_reg = 32'hFFFF_FF00;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors = 0;
  int        accepted_in = 0;
  bit        free_run = 1'b0;
  bit        sender_hold = 1'b0;
  int        long_hold = 0;
  longint    cycle_count = 0;
  int        gap = 0;
  int        stall_run = 0;
  logic      in_stall_o_q = 1'b1;

  function automatic bit ip_in_table(logic [31:0] a);
    for (int i = 0; i < n_hosts; i++) if (host_ip[i] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void reset_parse();
    pos = 0; kind = 0; hdr_ok = 1'b1; cur_mac = '0; cur_ip = '0;
  endfunction

  // work out the outcome of one accepted item
  function automatic void learn_item(in_item_t it);
    out_item_t r;
    int unsigned p, lim;
    logic [31:0] nw, bc, first, lst, range, start, tries, cand;
    bit ok;
    bit known;
    r = '0;
    if (it.cmd == CMD_SUGGEST) begin
      r.result_kind = 1'b1;
      nw = net_reg & mask_reg; bc = nw | ~mask_reg;
      first = nw + 1; lst = bc - 1;
      if (first < lst) begin
        range = lst - first + 1;
        start = it.seed % range;
        tries = n_hosts + 1;
        if (tries > range) tries = range;
        for (longint unsigned i = 0; i < tries; i++) begin
          cand = first + 32'((longint'(start) + i) % range);
          if (!ip_in_table(cand)) begin
            r.address_found = 1'b1; r.suggested_address = cand; break;
          end
        end
      end
    end else begin
      p = pos;
      if (p >= 6 && p <= 11) cur_mac = {cur_mac[39:0], it.frame_byte};
      else if (p == 12 || p == 13) kind = ((kind << 8) | it.frame_byte) & 16'hFFFF;
      else if (p >= 14 && kind == ETYPE_ARP) begin
        if (p == 14 && it.frame_byte != 8'h00) hdr_ok = 0;
        if (p == 15 && it.frame_byte != 8'h01) hdr_ok = 0;
        if (p == 16 && it.frame_byte != 8'h08) hdr_ok = 0;
        if (p == 17 && it.frame_byte != 8'h00) hdr_ok = 0;
        if (p == 18 && it.frame_byte != 8'd6) hdr_ok = 0;
        if (p == 19 && it.frame_byte != 8'd4) hdr_ok = 0;
        if (p >= 22 && p <= 27) cur_mac = {cur_mac[39:0], it.frame_byte};
        if (p >= 28 && p <= 31) cur_ip = {cur_ip[23:0], it.frame_byte};
      end else if (p >= 14 && kind == ETYPE_IP4) begin
        if (p == 14 && it.frame_byte[7:4] != 4'd4) hdr_ok = 0;
        if (p >= 26 && p <= 29) cur_ip = {cur_ip[23:0], it.frame_byte};
      end
      if (pos < 63) pos++;
      if (!it.last_byte) return;
      ok = 0;
      if (p >= 13 && hdr_ok) begin
        if (kind == ETYPE_ARP && p >= 41) ok = 1;
        if (kind == ETYPE_IP4 && p >= 33) ok = 1;
      end
      if (ok && cur_ip != 0) begin
        n_accepted++;
        known = 1'b0;
        for (int i = 0; i < n_hosts; i++)
          if (host_ip[i] == cur_ip) begin
            host_mac[i] = cur_mac; known = 1'b1;
          end
        lim = (lim_reg < TABLE_DEPTH) ? lim_reg : TABLE_DEPTH;
        if (!known && n_hosts < lim) begin
          host_ip[n_hosts] = cur_ip; host_mac[n_hosts] = cur_mac;
          n_hosts++; r.host_added = 1'b1;
        end
      end
      reset_parse();
    end
    r.hosts_known = 6'(n_hosts);
    r.frames_accepted = n_accepted;
    expected_results.push_back(r);
  endfunction

  // frame builders
  function automatic void push_byte(logic [7:0] b, bit lst);
    in_item_t it;
    it = '0; it.cmd = CMD_FRAME; it.frame_byte = b; it.last_byte = lst;
    it.seed = $urandom;
    pending_items.push_back(it);
  endfunction

  function automatic void push_suggest(logic [31:0] s);
    in_item_t it;
    it = '0; it.cmd = CMD_SUGGEST; it.seed = s;
    it.frame_byte = 8'($urandom); it.last_byte = 1'($urandom);
    pending_items.push_back(it);
  endfunction

  // arp or ipv4 frame; flaw breaks one header byte, len may shorten it
  function automatic void push_frame(bit arp, logic [31:0] ip, int len, bit flaw);
    logic [7:0] f[64];
    logic [47:0] mac;
    int bad;
    mac = 48'({$urandom, $urandom});
    for (int i = 0; i < 64; i++) f[i] = 8'($urandom);
    for (int i = 0; i < 6; i++) f[6 + i] = mac[47 - 8*i -: 8];
    f[12] = 8'h08; f[13] = arp ? 8'h06 : 8'h00;
    if (arp) begin
      f[14] = 8'h00; f[15] = 8'h01; f[16] = 8'h08; f[17] = 8'h00;
      f[18] = 8'd6; f[19] = 8'd4;
      for (int i = 0; i < 4; i++) f[28 + i] = ip[31 - 8*i -: 8];
      if (flaw) begin bad = $urandom_range(19, 14); f[bad] = f[bad] ^ 8'h10; end
    end else begin
      f[14] = {flaw ? 4'($urandom_range(15, 5)) : 4'd4, 4'($urandom)};
      for (int i = 0; i < 4; i++) f[26 + i] = ip[31 - 8*i -: 8];
    end
    for (int i = 0; i < len; i++) push_byte(f[i < 64 ? i : 63], i == len - 1);
  endfunction

  function automatic logic [31:0] pick_ip();
    case ($urandom_range(3))
      0: return net_reg & mask_reg | ($urandom_range(6) & ~mask_reg);
      1: return 32'h0;
      default: return $urandom_range(40);
    endcase
  endfunction

  // driver: falls on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o_q) begin
        accepted_in++;
      end
      if (in_valid_i && in_stall_o_q) begin
        // hold the payload
      end else if (gap > 0 || sender_hold || pending_items.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap > 0) gap--;
      end else if (!free_run && $urandom_range(9) == 0) begin
        in_valid_i <= 1'b0;
        gap = $urandom_range(12, 0);
      end else begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_items.pop_front();
      end
    end
  end

  // receiver: random hold-off bursts and one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold > 0) begin
        out_stall_i <= 1'b1; long_hold--;
      end else if (stall_run > 0) begin
        out_stall_i <= 1'b1; stall_run--;
      end else if (!free_run && $urandom_range(9) == 0) begin
        out_stall_i <= 1'b1; stall_run = $urandom_range(12, 0);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor: samples at the rising edge
  always @(posedge clk_i) begin
    in_stall_o_q <= in_stall_o;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (in_valid_i && !in_stall_o) learn_item(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %p", out_data_o);
          errors++;
        end else begin
          check_result(expected_results.pop_front(), out_data_o);
        end
      end
    end
  end

  function automatic void check_result(out_item_t e, out_item_t a);
    if (e.result_kind !== a.result_kind) begin
      $error("result_kind exp %0h got %0h", e.result_kind, a.result_kind); errors++; end
    if (e.host_added !== a.host_added) begin
      $error("host_added exp %0h got %0h", e.host_added, a.host_added); errors++; end
    if (e.address_found !== a.address_found) begin
      $error("address_found exp %0h got %0h", e.address_found, a.address_found);
      errors++; end
    if (e.suggested_address !== a.suggested_address) begin
      $error("suggested_address exp %0h got %0h", e.suggested_address,
             a.suggested_address); errors++; end
    if (e.hosts_known !== a.hosts_known) begin
      $error("hosts_known exp %0d got %0d", e.hosts_known, a.hosts_known); errors++; end
    if (e.frames_accepted !== a.frames_accepted) begin
      $error("frames_accepted exp %0d got %0d", e.frames_accepted, a.frames_accepted);
      errors++; end
  endfunction

  // wait until every item went in and every result came out
  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HOST_LIMIT:  lim_reg = val[5:0];
      CFG_SUBNET_ADDR: net_reg = val;
      default:         mask_reg = val;
    endcase
  endtask

  // generous watchdog
  always @(posedge clk_i) begin
    if (cycle_count > 1500000) begin
      $display("tb_passive_host_learning_table_core: FAIL");
      $finish;
    end
  end

  // queue about count more input items of random traffic
  task automatic random_phase(int count);
    int base;
    base = pending_items.size();
    while (pending_items.size() - base < count) begin
      case ($urandom_range(9))
        0, 1, 2: push_frame(1'b1, pick_ip(), $urandom_range(64, 42), $urandom_range(5) == 0);
        3, 4, 5: push_frame(1'b0, pick_ip(), $urandom_range(60, 34), $urandom_range(5) == 0);
        6: push_frame(1'($urandom_range(1)), pick_ip(), $urandom_range(33, 1), 1'b0);
        7: begin
          for (int i = $urandom_range(8, 1); i > 0; i--) push_byte(8'($urandom), 1'b0);
          push_byte(8'($urandom), 1'b1);
        end
        default: push_suggest($urandom);
      endcase
      if ($urandom_range(7) == 0) push_suggest($urandom);
    end
  endtask

  initial begin
    reset_parse();
    n_hosts = 0; n_accepted = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: extremes, both frame kinds, suggest on an empty table
    push_suggest(32'hFFFF_FFFF);
    push_byte(8'hFF, 1'b1);
    push_frame(1'b1, 32'h0000_0005, 42, 1'b0);
    push_frame(1'b1, 32'h0000_0005, 42, 1'b0);
    push_frame(1'b0, 32'hFFFF_FFFF, 34, 1'b0);
    push_frame(1'b1, 32'h0, 42, 1'b0);
    push_frame(1'b1, 32'h0000_0007, 41, 1'b0);
    push_frame(1'b0, 32'h0000_0009, 33, 1'b0);
    push_frame(1'b1, 32'h0000_0007, 42, 1'b1);
    push_frame(1'b0, 32'h0000_0008, 34, 1'b1);
    push_frame(1'b0, 32'h0000_0002, 64, 1'b0);
    push_byte(8'h00, 1'b0);
    push_suggest(32'h0);
    push_byte(8'h01, 1'b1);
    push_suggest(32'd4);
    push_suggest(32'd253);
    drain();

    // long receiver hold-off while the sender keeps going
    long_hold = 300;
    random_phase(200);
    drain();

    // small table, tiny subnet
    write_reg(CFG_HOST_LIMIT, 32'd3);
    write_reg(CFG_SUBNET_ADDR, 32'h0000_0000);
    write_reg(CFG_SUBNET_MASK, 32'hFFFF_FFF8);
    random_phase(300);
    drain();

    // sender pauses until everything is back
    sender_hold = 1'b1;
    drain();
    sender_hold = 1'b0;

    // degenerate subnets, zero limit
    write_reg(CFG_HOST_LIMIT, 32'd0);
    write_reg(CFG_SUBNET_MASK, 32'hFFFF_FFFE);
    random_phase(200);
    drain();
    write_reg(CFG_SUBNET_MASK, 32'hFFFF_FFFF);
    write_reg(CFG_SUBNET_ADDR, 32'hFFFF_FFFF);
    push_suggest($urandom);
    drain();

    // full-size table, wide subnet
    write_reg(CFG_HOST_LIMIT, 32'd63);
    write_reg(CFG_SUBNET_MASK, 32'h0000_0000);
    write_reg(CFG_SUBNET_ADDR, 32'h0000_0000);
    random_phase(250);
    drain();
    write_reg(CFG_SUBNET_MASK, 32'hFFFF_FFC0);
    random_phase(250);
    drain();

    // closing stretch with no idling
    free_run = 1'b1;
    random_phase(100);
    drain();

    if (errors == 0) begin
      $display("tb_passive_host_learning_table_core: PASS");
    end else begin
      $display("tb_passive_host_learning_table_core: FAIL");
    end
    $finish;
  end
endmodule

[files.f]
rtl/phlt_pkg.sv
rtl/phlt_cell.sv
rtl/phlt_mod_unit.sv
rtl/passive_host_learning_table_core.sv
dv/tb_passive_host_learning_table_core.sv
